### rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

### rtl/npz_pkg.sv
package npz_pkg;
  localparam int MUL_W  = 36;
  localparam int MUL_CW = $clog2(MUL_W);
  localparam int DIV_W  = 56;
  localparam int DIV_CW = $clog2(DIV_W);
  localparam int DIVS_W = 33;
  localparam int SQ_W   = 35;
  localparam int SQ_CW  = $clog2(SQ_W);

  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_CAP = 2'd1;
  localparam logic [1:0] STAT_DEG = 2'd2;
  localparam logic [1:0] STAT_SAT = 2'd3;

  localparam logic CFG_W_MASS    = 1'b0;
  localparam logic CFG_MAX_PULLS = 1'b1;
endpackage

### rtl/npz_mul.sv
module npz_mul (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [npz_pkg::MUL_W-1:0]       a,
  input  logic [npz_pkg::MUL_W-1:0]       b,
  output logic                            done,
  output logic [2*npz_pkg::MUL_W-1:0]     prod
);
  import npz_pkg::*;

  logic [MUL_W-1:0]  areg;
  logic [MUL_W-1:0]  hi;
  logic [MUL_W-1:0]  lo;
  logic [MUL_CW-1:0] cnt;
  logic              run;
  logic [MUL_W:0]    sum;

  assign sum  = {1'b0, hi} + (lo[0] ? {1'b0, areg} : '0);
  assign prod = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        areg <= a;
        hi   <= '0;
        lo   <= b;
        cnt  <= '0;
        run  <= 1'b1;
      end else if (run) begin
        hi  <= sum[MUL_W:1];
        lo  <= {sum[0], lo[MUL_W-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CW'(MUL_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### rtl/npz_div.sv
module npz_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [npz_pkg::DIV_W-1:0]   num,
  input  logic [npz_pkg::DIVS_W-1:0]  s,
  output logic                        done,
  output logic [npz_pkg::DIV_W-1:0]   quo
);
  import npz_pkg::*;

  logic [DIV_W-1:0]  n;
  logic [DIVS_W:0]   d;
  logic [DIVS_W:0]   rem;
  logic [DIVS_W+1:0] trial;
  logic [DIV_CW-1:0] cnt;
  logic              run;
  logic              fits;

  assign trial = {rem, n[DIV_W-1]};
  assign fits  = trial >= {1'b0, d};
  assign quo   = n;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        n   <= num + DIV_W'(s);
        d   <= {s, 1'b0};
        rem <= '0;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        rem <= fits ? (DIVS_W+1)'(trial - {1'b0, d}) : trial[DIVS_W:0];
        n   <= {n[DIV_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CW'(DIV_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### rtl/npz_sqrt.sv
module npz_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [2*npz_pkg::SQ_W-1:0]  rad,
  output logic                        done,
  output logic [npz_pkg::SQ_W-1:0]    root
);
  import npz_pkg::*;

  logic [2*SQ_W-1:0] x;
  logic [SQ_W:0]     rem;
  logic [SQ_W+2:0]   cur;
  logic [SQ_W+2:0]   trial;
  logic [SQ_CW-1:0]  cnt;
  logic              run;
  logic              fits;

  assign cur   = {rem, x[2*SQ_W-1:2*SQ_W-2]};
  assign trial = {1'b0, root, 2'b01};
  assign fits  = cur >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= rad;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
        run  <= 1'b1;
      end else if (run) begin
        rem  <= fits ? (SQ_W+1)'(cur - trial) : cur[SQ_W:0];
        root <= {root[SQ_W-2:0], fits};
        x    <= {x[2*SQ_W-3:0], 2'b00};
        cnt  <= cnt + 1'b1;
        if (cnt == SQ_CW'(SQ_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### rtl/neutrino_pz_from_w_mass.sv
// Neutrino pz from the W-mass constraint, built on bit-serial units: a
// shift-add multiplier, a restoring divider and a digit-by-digit square
// root, all driven by one sequencer. An item is taken when start is high
// and busy is low; busy then stays high until both results are out. The
// multiplier and divider passes set how long an item takes, and every pull
// adds passes of both; a degenerate lepton goes to the outputs straight
// after its first four products. The two results come on consecutive
// cycles, minus root first, each marked by done for one cycle; the
// receiver cannot stall them.
`include "assert_macros.svh"
module neutrino_pz_from_w_mass (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] lepton_px,
  input  logic signed [15:0] lepton_py,
  input  logic signed [15:0] lepton_pz,
  input  logic        [15:0] lepton_energy,
  input  logic signed [15:0] missing_px,
  input  logic signed [15:0] missing_py,
  output logic               done,
  output logic signed [15:0] neutrino_px,
  output logic signed [15:0] neutrino_py,
  output logic signed [19:0] neutrino_pz,
  output logic signed [19:0] neutrino_energy,
  output logic               is_last,
  output logic        [5:0]  pulls_used,
  output logic        [1:0]  status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic        [19:0] cfg_data
);
  import npz_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_PREP, S_L2, S_CMP, S_SQRT, S_PULL, S_DIV, S_OUT0, S_OUT1
  } state_t;

  typedef enum logic [3:0] {
    MO_E2, MO_PZ2, MO_PX2, MO_PY2, MO_T1, MO_T2, MO_Q1, MO_Q2,
    MO_LL, MO_K, MO_P, MO_Q, MO_U, MO_V
  } mop_t;

  state_t state;
  mop_t   mop;

  logic [19:0] w_mass;
  logic [5:0]  max_pulls;

  logic signed [15:0] lpx, lpy, lpz, mpx, mpy;
  logic        [15:0] en;
  logic [31:0] e2, pz2, px2, py2, q1, q2, mm;
  logic signed [31:0] t1, t2;
  logic signed [32:0] s_val;
  logic signed [34:0] m2;
  logic signed [35:0] l2;
  logic [71:0] ll, kk;
  logic [34:0] rr;
  logic signed [51:0] pv, qv, uv, vv;
  logic signed [19:0] npz0, ne0, npz1, ne1;
  logic sat0, sat1, cap, deg, axis, issued;
  logic [1:0] dop;
  logic [5:0] pulls;

  logic [MUL_W-1:0]   mul_a, mul_b;
  logic               mul_start, mul_done;
  logic [2*MUL_W-1:0] mul_prod;
  logic [DIV_W-1:0]   div_num, div_quo;
  logic [DIVS_W-1:0]  div_s;
  logic               div_start, div_done;
  logic               sq_start, sq_done;
  logic [SQ_W-1:0]    sq_root;

  logic [15:0] a_lpx, a_lpy, a_lpz, a_mpx, a_mpy;
  logic [35:0] a_l2;
  logic signed [32:0] s_calc;
  logic signed [16:0] dx, dy, dsel;
  logic signed [52:0] dsum;
  logic [52:0] a_dsum;
  logic [16:0] pq;
  logic signed [19:0] dres;
  logic               dsat;
  logic [51:0] pmag;

  assign a_lpx = lpx[15] ? 16'(-lpx) : 16'(lpx);
  assign a_lpy = lpy[15] ? 16'(-lpy) : 16'(lpy);
  assign a_lpz = lpz[15] ? 16'(-lpz) : 16'(lpz);
  assign a_mpx = mpx[15] ? 16'(-mpx) : 16'(mpx);
  assign a_mpy = mpy[15] ? 16'(-mpy) : 16'(mpy);
  assign a_l2  = l2[35] ? 36'(-l2) : 36'(l2);
  assign s_calc = $signed({1'b0, e2}) - $signed({1'b0, pz2});
  assign dx = 17'(lpx) - 17'(mpx);
  assign dy = 17'(lpy) - 17'(mpy);
  assign dsel = axis ? dy : dx;
  assign pmag = mul_prod[51:0];

  always_comb begin
    case (mop)
      MO_E2:   begin mul_a = 36'(en);    mul_b = 36'(en);    end
      MO_PZ2:  begin mul_a = 36'(a_lpz); mul_b = 36'(a_lpz); end
      MO_PX2:  begin mul_a = 36'(a_lpx); mul_b = 36'(a_lpx); end
      MO_PY2:  begin mul_a = 36'(a_lpy); mul_b = 36'(a_lpy); end
      MO_T1:   begin mul_a = 36'(a_mpx); mul_b = 36'(a_lpx); end
      MO_T2:   begin mul_a = 36'(a_mpy); mul_b = 36'(a_lpy); end
      MO_Q1:   begin mul_a = 36'(a_mpx); mul_b = 36'(a_mpx); end
      MO_Q2:   begin mul_a = 36'(a_mpy); mul_b = 36'(a_mpy); end
      MO_LL:   begin mul_a = a_l2;       mul_b = a_l2;       end
      MO_K:    begin mul_a = 36'(s_val[31:0]); mul_b = 36'(mm); end
      MO_P:    begin mul_a = 36'(a_lpz); mul_b = a_l2;       end
      MO_Q:    begin mul_a = 36'(en);    mul_b = 36'(rr);    end
      MO_U:    begin mul_a = 36'(en);    mul_b = a_l2;       end
      MO_V:    begin mul_a = 36'(a_lpz); mul_b = 36'(rr);    end
      default: begin mul_a = '0;         mul_b = '0;         end
    endcase
  end

  always_comb begin
    case (dop)
      2'd0:    dsum = 53'(pv) - 53'(qv);
      2'd1:    dsum = 53'(uv) - 53'(vv);
      2'd2:    dsum = 53'(pv) + 53'(qv);
      default: dsum = 53'(uv) + 53'(vv);
    endcase
  end

  assign a_dsum = dsum[52] ? 53'(-dsum) : 53'(dsum);

  always_comb begin
    if (state == S_PULL) begin
      div_num = DIV_W'(dsel[16] ? 17'(-dsel) : 17'(dsel));
      div_s   = DIVS_W'(5);
    end else begin
      div_num = DIV_W'(a_dsum);
      div_s   = s_val;
    end
  end

  always_comb begin
    dsat = 1'b0;
    if (dsum[52]) begin
      if (div_quo > DIV_W'(524288)) begin
        dres = -20'sd524288;
        dsat = 1'b1;
      end else begin
        dres = 20'(-div_quo[19:0]);
      end
    end else begin
      if (div_quo > DIV_W'(524287)) begin
        dres = 20'sd524287;
        dsat = 1'b1;
      end else begin
        dres = 20'(div_quo[19:0]);
      end
    end
  end

  assign pq = div_quo[16:0];

  assign mul_start = (state == S_MUL) && !issued;
  assign div_start = ((state == S_PULL) || (state == S_DIV)) && !issued;
  assign sq_start  = (state == S_SQRT) && !issued;

  npz_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_prod)
  );

  npz_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .s(div_s),
    .done(div_done), .quo(div_quo)
  );

  npz_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .rad(ll[69:0] - kk[69:0]),
    .done(sq_done), .root(sq_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mop       <= MO_E2;
      issued    <= 1'b0;
      w_mass    <= 20'd103388;
      max_pulls <= 6'd32;
      pulls     <= '0;
      dop       <= '0;
      axis      <= 1'b0;
      cap       <= 1'b0;
      deg       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_W_MASS:    w_mass    <= cfg_data;
          CFG_MAX_PULLS: max_pulls <= cfg_data[5:0];
          default:       ;
        endcase
      end
      if (mul_start || div_start || sq_start) issued <= 1'b1;
      case (state)
        S_IDLE: begin
          if (start) begin
            lpx   <= lepton_px;
            lpy   <= lepton_py;
            lpz   <= lepton_pz;
            en    <= lepton_energy;
            mpx   <= missing_px;
            mpy   <= missing_py;
            pulls <= '0;
            cap   <= 1'b0;
            deg   <= 1'b0;
            mop   <= MO_E2;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            issued <= 1'b0;
            case (mop)
              MO_E2:  begin e2  <= mul_prod[31:0]; mop <= MO_PZ2; end
              MO_PZ2: begin pz2 <= mul_prod[31:0]; mop <= MO_PX2; end
              MO_PX2: begin px2 <= mul_prod[31:0]; mop <= MO_PY2; end
              MO_PY2: begin py2 <= mul_prod[31:0]; state <= S_PREP; end
              MO_T1: begin
                t1  <= (mpx[15] ^ lpx[15]) ? 32'(-mul_prod[31:0]) : mul_prod[31:0];
                mop <= MO_T2;
              end
              MO_T2: begin
                t2  <= (mpy[15] ^ lpy[15]) ? 32'(-mul_prod[31:0]) : mul_prod[31:0];
                mop <= MO_Q1;
              end
              MO_Q1: begin q1 <= mul_prod[31:0]; mop <= MO_Q2; end
              MO_Q2: begin q2 <= mul_prod[31:0]; state <= S_L2; end
              MO_LL: begin ll <= mul_prod; mop <= MO_K; end
              MO_K:  begin kk <= {mul_prod[69:0], 2'b00}; state <= S_CMP; end
              MO_P: begin
                pv  <= (lpz[15] ^ l2[35]) ? 52'(-pmag) : pmag;
                mop <= MO_Q;
              end
              MO_Q: begin
                qv  <= lpz[15] ? 52'(-pmag) : pmag;
                mop <= MO_U;
              end
              MO_U: begin
                uv  <= l2[35] ? 52'(-pmag) : pmag;
                mop <= MO_V;
              end
              default: begin
                vv    <= pmag;
                dop   <= '0;
                state <= S_DIV;
              end
            endcase
          end
        end
        S_PREP: begin
          s_val <= s_calc;
          m2    <= $signed({3'b0, e2}) - $signed({3'b0, px2})
                 - $signed({3'b0, py2}) - $signed({3'b0, pz2});
          if (s_calc[32] || (s_calc == '0)) begin
            deg   <= 1'b1;
            npz0  <= '0;
            ne0   <= '0;
            npz1  <= '0;
            ne1   <= '0;
            sat0  <= 1'b0;
            sat1  <= 1'b0;
            state <= S_OUT0;
          end else begin
            mop   <= MO_T1;
            state <= S_MUL;
          end
        end
        S_L2: begin
          l2    <= $signed({16'b0, w_mass}) - 36'(m2) + ((36'(t1) + 36'(t2)) <<< 1);
          mm    <= q1 + q2;
          mop   <= MO_LL;
          state <= S_MUL;
        end
        S_CMP: begin
          if (ll >= kk) begin
            state <= S_SQRT;
          end else if (pulls >= max_pulls) begin
            cap   <= 1'b1;
            rr    <= '0;
            mop   <= MO_P;
            state <= S_MUL;
          end else begin
            axis  <= 1'b0;
            state <= S_PULL;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            issued <= 1'b0;
            rr     <= sq_root;
            mop    <= MO_P;
            state  <= S_MUL;
          end
        end
        S_PULL: begin
          if (div_done) begin
            issued <= 1'b0;
            if (!axis) begin
              mpx  <= 16'(dx[16] ? 17'(mpx) - pq : 17'(mpx) + pq);
              axis <= 1'b1;
            end else begin
              mpy   <= 16'(dy[16] ? 17'(mpy) - pq : 17'(mpy) + pq);
              pulls <= pulls + 1'b1;
              mop   <= MO_T1;
              state <= S_MUL;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            issued <= 1'b0;
            dop    <= dop + 1'b1;
            case (dop)
              2'd0: begin npz0 <= dres; sat0 <= dsat; end
              2'd1: begin ne0 <= dres; sat0 <= sat0 | dsat; end
              2'd2: begin npz1 <= dres; sat1 <= dsat; end
              default: begin
                ne1   <= dres;
                sat1  <= sat1 | dsat;
                state <= S_OUT0;
              end
            endcase
          end
        end
        S_OUT0:  state <= S_OUT1;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy            = state != S_IDLE;
  assign cfg_ready       = 1'b1;
  assign done            = (state == S_OUT0) || (state == S_OUT1);
  assign is_last         = state == S_OUT1;
  assign neutrino_px     = mpx;
  assign neutrino_py     = mpy;
  assign neutrino_pz     = is_last ? npz1 : npz0;
  assign neutrino_energy = is_last ? ne1 : ne0;
  assign pulls_used      = pulls;
  assign status          = deg ? STAT_DEG
                         : (is_last ? sat1 : sat0) ? STAT_SAT
                         : cap ? STAT_CAP : STAT_OK;

  `ASSERT_CLK(a_take_busy, start && !busy |=> busy, "accepted beat did not raise busy")
  `ASSERT_CLK(a_pair, done && !is_last |=> done && is_last, "plus root missing after minus root")
  `ASSERT_CLK(a_end, done && is_last |=> !busy, "busy held after last result")
  `ASSERT_CLK(a_deg_pulls, done && status == STAT_DEG |-> pulls_used == 6'd0, "pulls on degenerate")
  `ASSERT_ALWAYS(a_done_busy, done |-> busy, "result outside busy window")
endmodule
